@@ sv/mcfe_pkg.sv @@
package mcfe_pkg;

   localparam int LIMIT_W     = 31;
   localparam int DATA_W      = 32;
   localparam int ADDR_W      = 5;
   localparam int POS_BITS    = 16;
   localparam int OTHER_BITS  = 12;
   localparam int DIV_BITS    = 16;
   localparam int NUM_W       = 32 + DIV_BITS;
   localparam int PIPE_STAGES = 2 + DIV_BITS;

   localparam logic [55:0] FIXED_PREFIX    = 56'hFF_FFFF_FFFF_FFFF;
   localparam logic [7:0]  CMD_ENABLE      = 8'hFC;
   localparam logic [7:0]  CMD_DISABLE     = 8'hFD;
   localparam logic [7:0]  CMD_SET_ZERO    = 8'hFE;
   localparam logic [7:0]  CMD_CLEAR_ERROR = 8'hFB;

   typedef enum logic [2:0] {
      REQ_MIT         = 3'd0,
      REQ_ENABLE      = 3'd1,
      REQ_DISABLE     = 3'd2,
      REQ_SET_ZERO    = 3'd3,
      REQ_CLEAR_ERROR = 3'd4
   } req_type_type;

   typedef enum logic [2:0] {
      CSR_POSITION_LIMIT = 3'd0,
      CSR_VELOCITY_LIMIT = 3'd1,
      CSR_TORQUE_LIMIT   = 3'd2,
      CSR_STIFFNESS_MIN  = 3'd3,
      CSR_STIFFNESS_MAX  = 3'd4,
      CSR_DAMPING_MIN    = 3'd5,
      CSR_DAMPING_MAX    = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [LIMIT_W-1:0] position_limit;
      logic [LIMIT_W-1:0] velocity_limit;
      logic [LIMIT_W-1:0] torque_limit;
      logic [LIMIT_W-1:0] stiffness_min;
      logic [LIMIT_W-1:0] stiffness_max;
      logic [LIMIT_W-1:0] damping_min;
      logic [LIMIT_W-1:0] damping_max;
   } cfg_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic       motor_offline;
   } ctl_type;

endpackage

@@ sv/motor_command_frame_encoder.sv @@
// Channel   Direction  Handshake                   Payload
// req       in         req_valid / req_ready       command type, offline flag, five setpoints
// rsp       out        rsp_valid / rsp_ready       64-bit frame payload, send status
// csr       in         csr_psel / csr_penable      seven range registers, pready tied high
//
// One transaction enters per cycle unless the output stalls with every stage full.
// Clamp and scaling stages feed a 16-stage restoring divider that drives the output register.
// Reset clears all valid bits and loads the range registers with their default values.
// A stalled output holds its result while bubbles in the pipeline still fill from the input.
module motor_command_frame_encoder import mcfe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [2:0]        req_type,
   input  logic              req_motor_offline,
   input  logic signed [31:0] req_target_position,
   input  logic signed [31:0] req_target_velocity,
   input  logic signed [31:0] req_stiffness_gain,
   input  logic signed [31:0] req_damping_gain,
   input  logic signed [31:0] req_feedforward_torque,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [63:0]       rsp_frame_payload,
   output logic              rsp_send_status,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int NS = PIPE_STAGES;

   cfg_type cfg;

   mcfe_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;

   logic [NS-1:0] vld_ff;
   logic [NS-1:0] free;
   logic          out_free;
   ctl_type       ctl_ff [NS];
   ctl_type       req_ctl;

   assign out_free = !rsp_valid || rsp_ready;
   assign req_ready = free[0];
   assign req_ctl = '{req_type: req_type, motor_offline: req_motor_offline};

   for (genvar i = 0; i < NS; i++) begin : g_stage
      assign free[i] = out_free | ~(&vld_ff[NS-1:i]);

      if (i == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else if (free[i]) begin
               vld_ff[i] <= req_valid;
            end
         end
         always_ff @(posedge clock) begin
            if (free[i]) begin
               ctl_ff[i] <= req_ctl;
            end
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else if (free[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
         always_ff @(posedge clock) begin
            if (free[i]) begin
               ctl_ff[i] <= ctl_ff[i-1];
            end
         end
      end
   end

   logic signed [32:0] pos_lo, pos_hi, vel_lo, vel_hi, trq_lo, trq_hi;
   logic signed [32:0] kp_lo, kp_hi, kd_lo, kd_hi;

   assign pos_hi = $signed({2'b00, cfg.position_limit});
   assign pos_lo = -pos_hi;
   assign vel_hi = $signed({2'b00, cfg.velocity_limit});
   assign vel_lo = -vel_hi;
   assign trq_hi = $signed({2'b00, cfg.torque_limit});
   assign trq_lo = -trq_hi;
   assign kp_lo  = $signed({2'b00, cfg.stiffness_min});
   assign kp_hi  = $signed({2'b00, cfg.stiffness_max});
   assign kd_lo  = $signed({2'b00, cfg.damping_min});
   assign kd_hi  = $signed({2'b00, cfg.damping_max});

   logic [POS_BITS-1:0]   pos_code;
   logic [OTHER_BITS-1:0] vel_code, kp_code, kd_code, trq_code;

   mcfe_map_lane #(.CODE_BITS(POS_BITS)) u_pos (
      .clock (clock), .en (free), .x (req_target_position),
      .lo (pos_lo), .hi (pos_hi), .code (pos_code)
   );

   mcfe_map_lane #(.CODE_BITS(OTHER_BITS)) u_vel (
      .clock (clock), .en (free), .x (req_target_velocity),
      .lo (vel_lo), .hi (vel_hi), .code (vel_code)
   );

   mcfe_map_lane #(.CODE_BITS(OTHER_BITS)) u_kp (
      .clock (clock), .en (free), .x (req_stiffness_gain),
      .lo (kp_lo), .hi (kp_hi), .code (kp_code)
   );

   mcfe_map_lane #(.CODE_BITS(OTHER_BITS)) u_kd (
      .clock (clock), .en (free), .x (req_damping_gain),
      .lo (kd_lo), .hi (kd_hi), .code (kd_code)
   );

   mcfe_map_lane #(.CODE_BITS(OTHER_BITS)) u_trq (
      .clock (clock), .en (free), .x (req_feedforward_torque),
      .lo (trq_lo), .hi (trq_hi), .code (trq_code)
   );

   logic        rsp_valid_ff;
   logic [63:0] payload_in, payload_ff;
   logic        status_in, status_ff;
   ctl_type     last_ctl;

   assign last_ctl = ctl_ff[NS-1];

   always_comb begin
      payload_in = '0;
      status_in  = 1'b0;
      unique case (last_ctl.req_type)
         REQ_MIT: begin
            if (last_ctl.motor_offline) begin
               status_in = 1'b1;
            end else begin
               payload_in = {pos_code, vel_code, kp_code, kd_code, trq_code};
            end
         end
         REQ_ENABLE:      payload_in = {FIXED_PREFIX, CMD_ENABLE};
         REQ_DISABLE:     payload_in = {FIXED_PREFIX, CMD_DISABLE};
         REQ_SET_ZERO:    payload_in = {FIXED_PREFIX, CMD_SET_ZERO};
         REQ_CLEAR_ERROR: payload_in = {FIXED_PREFIX, CMD_CLEAR_ERROR};
         default:         status_in  = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= vld_ff[NS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         payload_ff <= payload_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_payload = payload_ff;
   assign rsp_send_status   = status_ff;

endmodule

@@ sv/mcfe_csr.sv @@
module mcfe_csr import mcfe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign idx = paddr[4:2];
   assign wr  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            CSR_POSITION_LIMIT: cfg_in.position_limit = pwdata[LIMIT_W-1:0];
            CSR_VELOCITY_LIMIT: cfg_in.velocity_limit = pwdata[LIMIT_W-1:0];
            CSR_TORQUE_LIMIT:   cfg_in.torque_limit   = pwdata[LIMIT_W-1:0];
            CSR_STIFFNESS_MIN:  cfg_in.stiffness_min  = pwdata[LIMIT_W-1:0];
            CSR_STIFFNESS_MAX:  cfg_in.stiffness_max  = pwdata[LIMIT_W-1:0];
            CSR_DAMPING_MIN:    cfg_in.damping_min    = pwdata[LIMIT_W-1:0];
            CSR_DAMPING_MAX:    cfg_in.damping_max    = pwdata[LIMIT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.position_limit <= 31'd819200;
         cfg_ff.velocity_limit <= 31'd1966080;
         cfg_ff.torque_limit   <= 31'd655360;
         cfg_ff.stiffness_min  <= 31'd0;
         cfg_ff.stiffness_max  <= 31'd32768000;
         cfg_ff.damping_min    <= 31'd0;
         cfg_ff.damping_max    <= 31'd327680;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         CSR_POSITION_LIMIT: prdata = {1'b0, cfg_ff.position_limit};
         CSR_VELOCITY_LIMIT: prdata = {1'b0, cfg_ff.velocity_limit};
         CSR_TORQUE_LIMIT:   prdata = {1'b0, cfg_ff.torque_limit};
         CSR_STIFFNESS_MIN:  prdata = {1'b0, cfg_ff.stiffness_min};
         CSR_STIFFNESS_MAX:  prdata = {1'b0, cfg_ff.stiffness_max};
         CSR_DAMPING_MIN:    prdata = {1'b0, cfg_ff.damping_min};
         CSR_DAMPING_MAX:    prdata = {1'b0, cfg_ff.damping_max};
         default:            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ sv/mcfe_map_lane.sv @@
module mcfe_map_lane import mcfe_pkg::*; #(
   parameter int CODE_BITS = 12
) (
   input  logic                   clock,
   input  logic [PIPE_STAGES-1:0] en,
   input  logic signed [31:0]     x,
   input  logic signed [32:0]     lo,
   input  logic signed [32:0]     hi,
   output logic [CODE_BITS-1:0]   code
);

   logic signed [32:0] xs;
   logic signed [32:0] xc_in;
   logic signed [32:0] xc_ff;
   logic signed [32:0] lo_ff;
   logic signed [33:0] span_full;
   logic [31:0]        span_in;
   logic [31:0]        span_ff;
   logic               ok_in;
   logic               ok_ff;

   always_comb begin
      xs        = {x[31], x};
      span_full = {hi[32], hi} - {lo[32], lo};
      ok_in     = span_full > 34'sd0;
      span_in   = span_full[31:0];
      priority if (xs < lo) begin
         xc_in = lo;
      end else if (xs > hi) begin
         xc_in = hi;
      end else begin
         xc_in = xs;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         xc_ff   <= xc_in;
         lo_ff   <= lo;
         span_ff <= span_in;
         ok_ff   <= ok_in;
      end
   end

   // The numerator is the offset times (2^CODE_BITS - 1), built as a shift and subtract.
   logic [32:0]      offset;
   logic [NUM_W-1:0] offset_ext;
   logic [NUM_W-1:0] num_in;
   logic [31:0]      dvs_in;

   logic [NUM_W-1:0]     rem_ff [DIV_BITS];
   logic [31:0]          div_ff [DIV_BITS];
   logic [CODE_BITS-1:0] q_ff   [1:DIV_BITS];

   always_comb begin
      offset     = 33'(xc_ff - lo_ff);
      offset_ext = NUM_W'(offset[31:0]);
      num_in     = ok_ff ? ((offset_ext << CODE_BITS) - offset_ext) : '0;
      dvs_in     = ok_ff ? span_ff : 32'd1;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         rem_ff[0] <= num_in;
         div_ff[0] <= dvs_in;
      end
   end

   for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
      localparam int BIT = DIV_BITS - 1 - j;
      logic [CODE_BITS-1:0] q_prev;

      if (j == 0) begin : g_first
         assign q_prev = '0;
      end else begin : g_later
         assign q_prev = q_ff[j];
      end

      if (BIT < CODE_BITS) begin : g_bit
         logic [NUM_W-1:0] trial;
         logic             take;

         assign trial = NUM_W'(div_ff[j]) << BIT;
         assign take  = rem_ff[j] >= trial;

         always_ff @(posedge clock) begin
            if (en[2+j]) begin
               q_ff[j+1] <= take ? (q_prev | (CODE_BITS'(1) << BIT)) : q_prev;
            end
         end

         if (j < DIV_BITS - 1) begin : g_next
            always_ff @(posedge clock) begin
               if (en[2+j]) begin
                  rem_ff[j+1] <= take ? (rem_ff[j] - trial) : rem_ff[j];
                  div_ff[j+1] <= div_ff[j];
               end
            end
         end
      end else begin : g_pass
         always_ff @(posedge clock) begin
            if (en[2+j]) begin
               q_ff[j+1]   <= q_prev;
               rem_ff[j+1] <= rem_ff[j];
               div_ff[j+1] <= div_ff[j];
            end
         end
      end
   end

   assign code = q_ff[DIV_BITS];

endmodule

@@ verif/tb_top.sv @@
module tb_top import mcfe_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 25;

   typedef struct {
      logic [63:0] payload;
      logic        status;
   } frame_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [2:0]        req_type;
   logic              req_motor_offline;
   logic signed [31:0] req_target_position;
   logic signed [31:0] req_target_velocity;
   logic signed [31:0] req_stiffness_gain;
   logic signed [31:0] req_damping_gain;
   logic signed [31:0] req_feedforward_torque;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [63:0]       rsp_frame_payload;
   logic              rsp_send_status;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   cfg_type   range_cfg;
   frame_type expected_frames[$];
   int        error_count;
   bit        send_idle_on;
   logic      recv_idle_on;
   logic      hold_req;
   logic      hold_seen;
   int        hold_left;

   motor_command_frame_encoder u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_type               (req_type),
      .req_motor_offline      (req_motor_offline),
      .req_target_position    (req_target_position),
      .req_target_velocity    (req_target_velocity),
      .req_stiffness_gain     (req_stiffness_gain),
      .req_damping_gain       (req_damping_gain),
      .req_feedforward_torque (req_feedforward_torque),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_frame_payload      (rsp_frame_payload),
      .rsp_send_status        (rsp_send_status),
      .csr_psel               (csr_psel),
      .csr_penable            (csr_penable),
      .csr_pwrite             (csr_pwrite),
      .csr_paddr              (csr_paddr),
      .csr_pwdata             (csr_pwdata),
      .csr_prdata             (csr_prdata),
      .csr_pready             (csr_pready)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   function automatic logic [63:0] scale_code(longint x, longint lo, longint hi, int bits);
      longint          span;
      longint unsigned top;
      longint unsigned offset;
      longint unsigned quotient;
      span = hi - lo;
      top = (64'd1 << bits) - 64'd1;
      if (span <= 0) begin
         return '0;
      end
      if (x < lo) x = lo;
      if (x > hi) x = hi;
      offset = x - lo;
      quotient = (offset * top) / longint'(span);
      if (quotient > top) quotient = top;
      return quotient;
   endfunction

   function automatic frame_type predict_frame(logic [2:0] kind, logic offline,
                                               logic signed [31:0] pos, vel, kp, kd, tq);
      frame_type   f;
      longint      pl;
      longint      vl;
      longint      tl;
      logic [63:0] p;
      logic [63:0] v;
      logic [63:0] s;
      logic [63:0] d;
      logic [63:0] t;
      f.payload = '0;
      f.status = 1'b0;
      case (kind)
         REQ_MIT: begin
            if (offline) begin
               f.status = 1'b1;
            end else begin
               pl = range_cfg.position_limit;
               vl = range_cfg.velocity_limit;
               tl = range_cfg.torque_limit;
               p = scale_code(longint'(pos), -pl, pl, POS_BITS);
               v = scale_code(longint'(vel), -vl, vl, OTHER_BITS);
               s = scale_code(longint'(kp), longint'({1'b0, range_cfg.stiffness_min}),
                              longint'({1'b0, range_cfg.stiffness_max}), OTHER_BITS);
               d = scale_code(longint'(kd), longint'({1'b0, range_cfg.damping_min}),
                              longint'({1'b0, range_cfg.damping_max}), OTHER_BITS);
               t = scale_code(longint'(tq), -tl, tl, OTHER_BITS);
               f.payload = {p[15:0], v[11:0], s[11:0], d[11:0], t[11:0]};
            end
         end
         REQ_ENABLE:      f.payload = {FIXED_PREFIX, CMD_ENABLE};
         REQ_DISABLE:     f.payload = {FIXED_PREFIX, CMD_DISABLE};
         REQ_SET_ZERO:    f.payload = {FIXED_PREFIX, CMD_SET_ZERO};
         REQ_CLEAR_ERROR: f.payload = {FIXED_PREFIX, CMD_CLEAR_ERROR};
         default:         f.status = 1'b1;
      endcase
      return f;
   endfunction

   function automatic logic [31:0] pick_setpoint(longint lo, longint hi);
      longint swap;
      longint pad;
      longint val;
      if (lo > hi) begin
         swap = lo;
         lo = hi;
         hi = swap;
      end
      case ($urandom_range(9))
         0: return $urandom;
         1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         2: val = lo;
         3: val = hi;
         default: begin
            pad = (hi - lo) / 4 + 1;
            val = lo - pad + longint'({$urandom, $urandom} % (hi - lo + 2 * pad + 1));
         end
      endcase
      if (val < -64'sd2147483648) val = -64'sd2147483648;
      if (val > 64'sd2147483647) val = 64'sd2147483647;
      return val[31:0];
   endfunction

   function automatic logic [31:0] random_limit();
      return {1'($urandom_range(1)), 31'($urandom_range(1, 32'h7FFF_FFFF))};
   endfunction

   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (recv_idle_on) begin
         rsp_ready <= ($urandom_range(99) >= 6);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      frame_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_frames.size() == 0) begin
            $display("%0t: frame with no transaction pending, payload %h status %b",
                     $time, rsp_frame_payload, rsp_send_status);
            error_count++;
         end else begin
            want = expected_frames.pop_front();
            if (rsp_frame_payload !== want.payload) begin
               $display("%0t: payload mismatch, expected %h actual %h",
                        $time, want.payload, rsp_frame_payload);
               error_count++;
            end
            if (rsp_send_status !== want.status) begin
               $display("%0t: send status mismatch, expected %b actual %b",
                        $time, want.status, rsp_send_status);
               error_count++;
            end
         end
      end
   end

   task automatic send_command(logic [2:0] kind, logic offline,
                               logic [31:0] pos, vel, kp, kd, tq);
      req_valid <= 1'b1;
      req_type <= kind;
      req_motor_offline <= offline;
      req_target_position <= pos;
      req_target_velocity <= vel;
      req_stiffness_gain <= kp;
      req_damping_gain <= kd;
      req_feedforward_torque <= tq;
      do @(posedge clock); while (!req_ready);
      expected_frames.push_back(predict_frame(kind, offline, pos, vel, kp, kd, tq));
      if (send_idle_on && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic send_random_command();
      logic [2:0] kind;
      longint     pl;
      longint     vl;
      longint     tl;
      kind = ($urandom_range(99) < 75) ? REQ_MIT : 3'($urandom_range(7));
      pl = range_cfg.position_limit;
      vl = range_cfg.velocity_limit;
      tl = range_cfg.torque_limit;
      send_command(kind, $urandom_range(99) < 10,
                   pick_setpoint(-pl, pl), pick_setpoint(-vl, vl),
                   pick_setpoint(range_cfg.stiffness_min, range_cfg.stiffness_max),
                   pick_setpoint(range_cfg.damping_min, range_cfg.damping_max),
                   pick_setpoint(-tl, tl));
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
   endtask

   task automatic write_range_register(csr_index_type idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         CSR_POSITION_LIMIT: range_cfg.position_limit = value[LIMIT_W-1:0];
         CSR_VELOCITY_LIMIT: range_cfg.velocity_limit = value[LIMIT_W-1:0];
         CSR_TORQUE_LIMIT:   range_cfg.torque_limit = value[LIMIT_W-1:0];
         CSR_STIFFNESS_MIN:  range_cfg.stiffness_min = value[LIMIT_W-1:0];
         CSR_STIFFNESS_MAX:  range_cfg.stiffness_max = value[LIMIT_W-1:0];
         CSR_DAMPING_MIN:    range_cfg.damping_min = value[LIMIT_W-1:0];
         CSR_DAMPING_MAX:    range_cfg.damping_max = value[LIMIT_W-1:0];
         default: ;
      endcase
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[LIMIT_W-1:0] !== value[LIMIT_W-1:0]) begin
         $display("%0t: register %s readback mismatch, expected %h actual %h",
                  $time, idx.name(), value[LIMIT_W-1:0], csr_prdata[LIMIT_W-1:0]);
         error_count++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_ranges(logic [31:0] pos_lim, vel_lim, tq_lim,
                              stiff_lo, stiff_hi, damp_lo, damp_hi);
      write_range_register(CSR_POSITION_LIMIT, pos_lim);
      write_range_register(CSR_VELOCITY_LIMIT, vel_lim);
      write_range_register(CSR_TORQUE_LIMIT, tq_lim);
      write_range_register(CSR_STIFFNESS_MIN, stiff_lo);
      write_range_register(CSR_STIFFNESS_MAX, stiff_hi);
      write_range_register(CSR_DAMPING_MIN, damp_lo);
      write_range_register(CSR_DAMPING_MAX, damp_hi);
   endtask

   task automatic test_fixed_frames();
      for (int k = REQ_ENABLE; k <= 7; k++) begin
         send_command(3'(k), 1'b0, $urandom, $urandom, $urandom, $urandom, $urandom);
         if (k <= REQ_CLEAR_ERROR) begin
            send_command(3'(k), 1'b1, $urandom, $urandom, $urandom, $urandom, $urandom);
         end
      end
      wait_drain();
   endtask

   task automatic test_mit_extremes();
      logic [31:0] pl;
      logic [31:0] vl;
      logic [31:0] tl;
      logic [31:0] kmax;
      logic [31:0] dmax;
      pl = range_cfg.position_limit;
      vl = range_cfg.velocity_limit;
      tl = range_cfg.torque_limit;
      kmax = range_cfg.stiffness_max;
      dmax = range_cfg.damping_max;
      send_command(REQ_MIT, 1'b0, 0, 0, 0, 0, 0);
      send_command(REQ_MIT, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000);
      send_command(REQ_MIT, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_command(REQ_MIT, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_command(REQ_MIT, 1'b0, pl, vl, kmax, dmax, tl);
      send_command(REQ_MIT, 1'b0, -pl, -vl, 0, 0, -tl);
      send_command(REQ_MIT, 1'b0, pl + 1, vl + 1, kmax + 1, dmax + 1, tl + 1);
      send_command(REQ_MIT, 1'b0, -pl - 1, -vl - 1, -1, -1, -tl - 1);
      send_command(REQ_MIT, 1'b0, pl - 1, -vl + 1, kmax - 1, 1, tl - 1);
      send_command(REQ_MIT, 1'b0, pl, pl, pl, pl, pl);
      send_command(REQ_MIT, 1'b1, pl, vl, kmax, dmax, tl);
      send_command(REQ_MIT, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'hFFFF_FFFF, 1);
      wait_drain();
   endtask

   task automatic test_backpressure();
      send_idle_on = 1'b0;
      hold_req <= ~hold_req;
      repeat (60) send_random_command();
      send_idle_on = 1'b1;
      wait_drain();
   endtask

   task automatic test_range_settings();
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      for (int s = 0; s < 7; s++) begin
         a = $urandom_range(0, 32'h7FFF_FFFF);
         b = $urandom_range(0, 32'h7FFF_FFFF);
         c = $urandom_range(0, 32'h7FFF_FFFF);
         d = $urandom_range(0, 32'h7FFF_FFFF);
         if (a > b) {a, b} = {b, a};
         if (c > d) {c, d} = {d, c};
         case (s)
            0: load_ranges(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           0, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF);
            1: load_ranges(1, 1, 1, 5000, 5000, 300000, 100);
            2: load_ranges($urandom_range(1, 4096), $urandom_range(1, 4096),
                           $urandom_range(1, 4096), 32'h7FFF_FFFF, 0, 0, 0);
            3, 4: load_ranges(random_limit(), random_limit(), random_limit(),
                              {1'($urandom_range(1)), a[30:0]},
                              {1'($urandom_range(1)), b[30:0]},
                              {1'($urandom_range(1)), c[30:0]},
                              {1'($urandom_range(1)), d[30:0]});
            5: load_ranges($urandom_range(65536, 4194304), $urandom_range(65536, 4194304),
                           $urandom_range(65536, 4194304), $urandom_range(0, 65536),
                           $urandom_range(1000000, 40000000), $urandom_range(0, 4096),
                           $urandom_range(100000, 1000000));
            default: load_ranges(819200, 1966080, 655360, 0, 32768000, 0, 327680);
         endcase
         if (s == 6) begin
            send_idle_on = 1'b0;
            recv_idle_on <= 1'b0;
         end
         repeat (100) send_random_command();
         wait_drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = REQ_MIT;
      req_motor_offline = 1'b0;
      req_target_position = '0;
      req_target_velocity = '0;
      req_stiffness_gain = '0;
      req_damping_gain = '0;
      req_feedforward_torque = '0;
      rsp_ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      hold_req = 1'b0;
      hold_seen = 1'b0;
      hold_left = 0;
      recv_idle_on = 1'b1;
      send_idle_on = 1'b1;
      error_count = 0;
      range_cfg.position_limit = 819200;
      range_cfg.velocity_limit = 1966080;
      range_cfg.torque_limit = 655360;
      range_cfg.stiffness_min = 0;
      range_cfg.stiffness_max = 32768000;
      range_cfg.damping_min = 0;
      range_cfg.damping_max = 327680;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fixed_frames();
      test_mit_extremes();
      test_backpressure();
      test_range_settings();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
